### rtl/bmpd_pkg.sv
// Shared types and constants for the BMP pixel stream decoder.
package bmpd_pkg;

    // Header layout: byte positions of the little-endian fields
    localparam int HDR_LEN      = 54;
    localparam int HDR_LAST     = HDR_LEN - 1;
    localparam int POS_OFFSET   = 10;
    localparam int POS_HSIZE    = 14;
    localparam int POS_WIDTH    = 18;
    localparam int POS_HEIGHT   = 22;
    localparam int POS_PLANES   = 26;
    localparam int POS_BITS     = 28;
    localparam int POS_COMP     = 30;

    // Header check limits
    localparam int MIN_HDR_SIZE = 40;
    localparam int BPP_24       = 24;
    localparam int BPP_32       = 32;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Result kinds
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Depth of the queue between parser and output stage
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TRUNC   = 2'd1,
        ST_LAYOUT  = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    // One queue entry: a pixel, a status, or a pixel followed by a status
    typedef struct packed {
        logic        has_pix;
        logic        has_stat;
        logic [11:0] x;
        logic [11:0] y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        t_status     code;
        logic [12:0] img_w;
        logic [12:0] img_h;
    } t_entry;

endpackage

### rtl/bmpd_front.sv
// Byte parser: header capture and check, offset skip, pixel assembly.
module bmpd_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last_byte,
    input  logic             i_full,
    output logic             o_push,
    output bmpd_pkg::t_entry o_entry
);
    import bmpd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_SKIP   = 4'b0010,
        PH_PIXEL  = 4'b0100,
        PH_DONE   = 4'b1000
    } t_phase;

    // Control state
    t_phase          r_phase, n_phase;
    logic [31:0]     r_pos, n_pos;
    logic [CW-1:0]   r_col, n_col;
    logic [RW-1:0]   r_row, n_row;
    logic [1:0]      r_k, n_k;
    logic [1:0]      r_pad, n_pad;
    t_status         r_err, n_err;

    // Captured header fields
    logic [31:0]     r_offset, n_offset;
    logic [31:0]     r_hsize, n_hsize;
    logic [31:0]     r_width, n_width;
    logic [31:0]     r_height, n_height;
    logic [31:0]     r_comp, n_comp;
    logic [15:0]     r_planes, n_planes;
    logic [15:0]     r_bits, n_bits;

    // Image geometry settled by the header check
    logic [CW-1:0]   r_wid, n_wid;
    logic [RW-1:0]   r_hgt, n_hgt;
    logic            r_topdown, n_topdown;
    logic            r_is32, n_is32;
    logic [1:0]      r_pad_row, n_pad_row;
    logic [23:0]     r_hold, n_hold;

    logic            w_accept;
    logic [31:0]     w_habs;
    t_status         w_chk;

    assign w_accept = i_valid && !i_full;

    // Header check on the captured fields
    always_comb begin
        w_habs = r_height[31] ? (32'd0 - r_height) : r_height;
        if (r_hsize < 32'(MIN_HDR_SIZE)) begin
            w_chk = ST_TRUNC;
        end else if (r_width == 32'd0 || w_habs == 32'd0 || r_planes != 16'd1 ||
                     (r_bits != 16'(BPP_24) && r_bits != 16'(BPP_32)) ||
                     r_comp != 32'd0) begin
            w_chk = ST_LAYOUT;
        end else if (r_width > 32'(MAX_WIDTH) || w_habs > 32'(MAX_HEIGHT) ||
                     r_offset < 32'(HDR_LEN)) begin
            w_chk = ST_INVALID;
        end else begin
            w_chk = ST_OK;
        end
    end

    // Next-state and entry build for the accepted byte
    always_comb begin
        logic          do_pix;
        logic          emit;
        logic [RW-1:0] yv;
        logic [31:0]   t32;
        t_status       code;

        n_phase   = r_phase;
        n_pos     = r_pos;
        n_col     = r_col;
        n_row     = r_row;
        n_k       = r_k;
        n_pad     = r_pad;
        n_err     = r_err;
        n_offset  = r_offset;
        n_hsize   = r_hsize;
        n_width   = r_width;
        n_height  = r_height;
        n_comp    = r_comp;
        n_planes  = r_planes;
        n_bits    = r_bits;
        n_wid     = r_wid;
        n_hgt     = r_hgt;
        n_topdown = r_topdown;
        n_is32    = r_is32;
        n_pad_row = r_pad_row;
        n_hold    = r_hold;
        do_pix    = 1'b0;
        emit      = 1'b0;
        yv        = '0;
        t32       = '0;
        code      = ST_OK;
        o_entry   = '0;

        if (w_accept) begin
            unique case (r_phase)
                PH_HEADER: begin
                    // little-endian fields shift in from the top
                    unique case (r_pos[5:0]) inside
                        [POS_OFFSET:POS_OFFSET+3]: n_offset = {i_data_byte, r_offset[31:8]};
                        [POS_HSIZE:POS_HSIZE+3]:   n_hsize  = {i_data_byte, r_hsize[31:8]};
                        [POS_WIDTH:POS_WIDTH+3]:   n_width  = {i_data_byte, r_width[31:8]};
                        [POS_HEIGHT:POS_HEIGHT+3]: n_height = {i_data_byte, r_height[31:8]};
                        [POS_PLANES:POS_PLANES+1]: n_planes = {i_data_byte, r_planes[15:8]};
                        [POS_BITS:POS_BITS+1]:     n_bits   = {i_data_byte, r_bits[15:8]};
                        [POS_COMP:POS_COMP+3]:     n_comp   = {i_data_byte, r_comp[31:8]};
                        default: ;
                    endcase
                    if (r_pos[5:0] == 6'(HDR_LAST)) begin
                        n_err     = w_chk;
                        n_phase   = (w_chk != ST_OK) ? PH_DONE : PH_SKIP;
                        n_wid     = r_width[CW-1:0];
                        n_hgt     = w_habs[RW-1:0];
                        n_topdown = r_height[31];
                        n_is32    = (r_bits == 16'(BPP_32));
                        n_pad_row = (r_bits == 16'(BPP_32)) ? 2'd0 : r_width[1:0];
                    end
                end
                PH_SKIP: begin
                    if (r_pos >= r_offset) begin
                        n_phase = PH_PIXEL;
                        do_pix  = 1'b1;
                    end
                end
                PH_PIXEL: do_pix = 1'b1;
                PH_DONE:  ;
                default:  ;
            endcase

            // Pixel byte: padding drop, channel gather, or pixel emit
            if (do_pix) begin
                if (r_pad != 2'd0) begin
                    n_pad = r_pad - 2'd1;
                    if (r_pad == 2'd1) begin
                        n_col = '0;
                        n_row = r_row + RW'(1);
                        if (r_row + RW'(1) == r_hgt) n_phase = PH_DONE;
                    end
                end else if (r_k != (r_is32 ? 2'd3 : 2'd2)) begin
                    case (r_k)
                        2'd0:    n_hold = {16'd0, i_data_byte};
                        2'd1:    n_hold[15:8] = i_data_byte;
                        default: n_hold[23:16] = i_data_byte;
                    endcase
                    n_k = r_k + 2'd1;
                end else begin
                    emit            = 1'b1;
                    yv              = r_topdown ? r_row : (r_hgt - RW'(1) - r_row);
                    t32             = 32'(r_col);
                    o_entry.x       = t32[11:0];
                    t32             = 32'(yv);
                    o_entry.y       = t32[11:0];
                    o_entry.red     = r_is32 ? r_hold[23:16] : i_data_byte;
                    o_entry.alpha   = r_is32 ? i_data_byte : ALPHA_OPAQUE;
                    o_entry.green   = r_hold[15:8];
                    o_entry.blue    = r_hold[7:0];
                    n_k             = 2'd0;
                    n_col           = r_col + CW'(1);
                    if (r_col + CW'(1) == r_wid) begin
                        n_col = '0;
                        if (r_pad_row != 2'd0) begin
                            n_pad = r_pad_row;
                        end else begin
                            n_row = r_row + RW'(1);
                            if (r_row + RW'(1) == r_hgt) n_phase = PH_DONE;
                        end
                    end
                end
            end

            if (r_pos != 32'hFFFF_FFFF) n_pos = r_pos + 32'd1;

            // Final byte: status, then back to the start of a new file
            if (i_last_byte) begin
                if (n_err != ST_OK)          code = n_err;
                else if (n_phase == PH_HEADER) code = ST_TRUNC;
                else if (n_phase != PH_DONE)   code = ST_INVALID;
                else                           code = ST_OK;
                o_entry.has_stat = 1'b1;
                o_entry.code     = code;
                if (code == ST_OK) begin
                    t32           = 32'(n_wid);
                    o_entry.img_w = t32[12:0];
                    t32           = 32'(n_hgt);
                    o_entry.img_h = t32[12:0];
                end
                n_phase = PH_HEADER;
                n_pos   = '0;
                n_col   = '0;
                n_row   = '0;
                n_k     = 2'd0;
                n_pad   = 2'd0;
                n_err   = ST_OK;
            end
        end

        o_entry.has_pix = emit;
        o_push          = w_accept && (emit || i_last_byte);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_k     <= 2'd0;
            r_pad   <= 2'd0;
            r_err   <= ST_OK;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_col   <= n_col;
            r_row   <= n_row;
            r_k     <= n_k;
            r_pad   <= n_pad;
            r_err   <= n_err;
        end
    end

    // Header fields, geometry and pixel gather
    always_ff @(posedge i_clk) begin
        r_offset  <= n_offset;
        r_hsize   <= n_hsize;
        r_width   <= n_width;
        r_height  <= n_height;
        r_comp    <= n_comp;
        r_planes  <= n_planes;
        r_bits    <= n_bits;
        r_wid     <= n_wid;
        r_hgt     <= n_hgt;
        r_topdown <= n_topdown;
        r_is32    <= n_is32;
        r_pad_row <= n_pad_row;
        r_hold    <= n_hold;
    end

endmodule

### rtl/bmpd_queue.sv
// Short entry queue between the byte parser and the output stage.
module bmpd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bmpd_pkg::t_entry i_entry,
    input  logic             i_pop,
    output bmpd_pkg::t_entry o_entry,
    output logic             o_full,
    output logic             o_empty
);
    import bmpd_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_entry          r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [NW-1:0]   r_count;

    assign o_entry = r_mem[r_rd];
    assign o_full  = (r_count == NW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + PW'(1);
            if (i_pop)  r_rd <= r_rd + PW'(1);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + NW'(1);
                2'b01:   r_count <= r_count - NW'(1);
                default: ;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_entry;
    end

endmodule

### rtl/bmpd_back.sv
// Output stage: splits queue entries into results and holds the output register.
module bmpd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bmpd_pkg::t_entry i_entry,
    input  logic             i_empty,
    output logic             o_pop,
    input  logic             i_stall,
    output logic             o_valid,
    output logic             o_result_kind,
    output logic [11:0]      o_pixel_x,
    output logic [11:0]      o_pixel_y,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [7:0]       o_alpha,
    output logic [1:0]       o_status_code,
    output logic [12:0]      o_image_width,
    output logic [12:0]      o_image_height
);
    import bmpd_pkg::*;

    logic   r_valid;
    logic   r_pend;
    t_entry r_out, n_out;
    t_entry r_pend_ent;
    t_entry w_pix_view, w_stat_view;
    logic   w_load;

    assign w_load = !r_valid || !i_stall;
    assign o_pop  = w_load && !r_pend && !i_empty;

    // Pixel-only and status-only views of the head entry
    always_comb begin
        w_pix_view          = i_entry;
        w_pix_view.has_stat = 1'b0;
        w_pix_view.code     = ST_OK;
        w_pix_view.img_w    = '0;
        w_pix_view.img_h    = '0;

        w_stat_view          = '0;
        w_stat_view.has_stat = 1'b1;
        w_stat_view.code     = i_entry.code;
        w_stat_view.img_w    = i_entry.img_w;
        w_stat_view.img_h    = i_entry.img_h;
    end

    // Next result: a held status goes first, then the queue head
    always_comb begin
        if (r_pend)                n_out = r_pend_ent;
        else if (i_entry.has_pix)  n_out = w_pix_view;
        else                       n_out = w_stat_view;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (w_load) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else if (!i_empty) begin
                r_valid <= 1'b1;
                r_pend  <= i_entry.has_pix && i_entry.has_stat;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && (r_pend || !i_empty)) r_out <= n_out;
        if (o_pop) r_pend_ent <= w_stat_view;
    end

    assign o_valid        = r_valid;
    assign o_result_kind  = r_out.has_pix ? KIND_PIXEL : KIND_STATUS;
    assign o_pixel_x      = r_out.x;
    assign o_pixel_y      = r_out.y;
    assign o_red          = r_out.red;
    assign o_green        = r_out.green;
    assign o_blue         = r_out.blue;
    assign o_alpha        = r_out.alpha;
    assign o_status_code  = r_out.code;
    assign o_image_width  = r_out.img_w;
    assign o_image_height = r_out.img_h;

endmodule

### rtl/bmp_pixel_stream_decoder.sv
// Top level of the BMP pixel stream decoder: parser, queue and output stage.
//
// Usage: a BMP file (uncompressed, 24 or 32 bits per pixel) enters one byte
// per request on the input channel (i_valid / o_stall), with i_last_byte set
// on the final byte. Results leave on the output channel (o_valid / i_stall):
// a pixel result (kind 0) carries column, row (top row is 0) and RGBA; the
// status result (kind 1) follows the last byte and carries the status code
// and, when the code is ok, the image width and absolute height.
// Throughput: one byte per cycle while o_stall is low. The final byte may
// yield a pixel and the status; those two leave as separate results, the
// pixel first. The parser writes its entry into the queue at the edge that
// accepts the byte, and the output register loads it from the queue head
// once that register is empty or its result is taken, so results are registered.
// A four-entry queue sits between the parser and the output stage; o_stall
// rises only when that queue is full. With the receiver stalled, the output
// register and four queued entries fill before the input stalls; header,
// skipped and padding bytes push nothing. A stalled result holds steady.
// Reset (synchronous, active low) returns to the start of a file; after
// each status result the decoder also starts a new file.
module bmp_pixel_stream_decoder #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_result_kind,
    output logic [11:0] o_pixel_x,
    output logic [11:0] o_pixel_y,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic [1:0]  o_status_code,
    output logic [12:0] o_image_width,
    output logic [12:0] o_image_height
);
    import bmpd_pkg::*;

    logic   w_push, w_pop, w_full, w_empty;
    t_entry w_push_ent, w_head_ent;

    assign o_stall = w_full;

    // Byte parser
    bmpd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_entry     (w_push_ent)
    );

    // Entry queue
    bmpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_ent),
        .i_pop   (w_pop),
        .o_entry (w_head_ent),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // Output stage
    bmpd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_entry        (w_head_ent),
        .i_empty        (w_empty),
        .o_pop          (w_pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_result_kind  (o_result_kind),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_alpha        (o_alpha),
        .o_status_code  (o_status_code),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height)
    );

    // Queue never takes an entry while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("entry queue overflow");

    // Output stage never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("entry queue underflow");

    // A pixel result never carries a status code
    a_pixel_status_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_kind == KIND_PIXEL) |-> (o_status_code == ST_OK))
        else $error("pixel result with nonzero status");

endmodule
